// ===== rtl/pknn_pkg.sv =====
// Package for the prior-point k-nearest-neighbor search block.
// Holds widths, defaults, the state type and the item structs; depends on nothing.
package pknn_pkg;

    localparam int COORD_BITS        = 16;
    localparam int INDEX_BITS        = 10;
    localparam int DIST_BITS         = 2 * COORD_BITS + 1;
    localparam int NCOUNT_BITS       = 5;
    localparam logic [NCOUNT_BITS-1:0] NCOUNT_RESET = NCOUNT_BITS'(15);
    localparam int MAX_POINTS_DEF    = 1024;
    localparam int MAX_NEIGHBORS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         new_set;
    } t_point_in;

    typedef struct packed {
        logic [INDEX_BITS-1:0] point_index;
        logic [INDEX_BITS-1:0] neighbor_index;
        logic [DIST_BITS-1:0]  distance_sq;
        logic                  last_neighbor;
    } t_result;

    // Control from the scan pipeline into the sorted neighbor list.
    typedef struct packed {
        logic                  clear;
        logic                  insert;
        logic [DIST_BITS-1:0]  cand_dist;
        logic [INDEX_BITS-1:0] idx;
    } t_list_ctl;

endpackage

// ===== rtl/prior_point_knn_search_top.sv =====
// Top level of the prior-point k-nearest-neighbor search block.
// Depends on pknn_pkg, pknn_ram and pknn_list.
//
// Usage: points arrive on the input channel (i_valid / o_ready, payload i_point).
// Each accepted point is stored in the coordinate RAM under the next index of
// the current set; new_set restarts the set at index 0. For every point after
// the first, the block streams all earlier points of the set out of the RAM,
// one per cycle, computes the squared distance in a four-stage pipeline and
// files it into a sorted list of up to neighbor_count entries, 0 acting as 1.
// The list then leaves on the output channel (o_valid / i_ready, payload
// o_result) in ascending distance order, one item per neighbor, with
// last_neighbor set on the final one. The first point of a set, and a point
// that arrives when the set is full, produce no items; the latter is not stored.
// A point that gives items holds the block through its scan, its output and a
// return to idle, in which the next point is taken; the scan is bound by the
// single RAM read port. A point that gives no items leaves the block idle.
// Only one point is in work at a time; o_ready is high while the block is
// idle. The output register lets a new point be taken while the last item
// waits; a stalled receiver simply holds the output stage, and the list waits
// behind it.
// Reset (synchronous, active low) empties the set, sets neighbor_count to 15
// and drops any item in flight. The coordinate RAM needs no clearing.
module prior_point_knn_search_top
    import pknn_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NCOUNT_BITS-1:0] i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_point_in              i_point,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_result                o_result
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NB_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int SEL_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SQ_W  = 2 * COORD_BITS;

    t_state r_state, n_state;

    logic [NCOUNT_BITS-1:0] r_ncount;
    logic [CNT_W-1:0]       r_cnt;
    logic [AW-1:0]          r_i;
    logic [AW-1:0]          r_j;
    logic [NB_W-1:0]        r_k;
    logic [NB_W-1:0]        r_e;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;

    // Distance pipeline: RAM read, absolute differences, squares, sum.
    logic                  r_rv0;
    logic [AW-1:0]         r_rj0;
    logic                  r_s1_v;
    logic [AW-1:0]         r_s1_j;
    logic [COORD_BITS-1:0] r_s1_dx, r_s1_dy;
    logic                  r_s2_v;
    logic [AW-1:0]         r_s2_j;
    logic [SQ_W-1:0]       r_s2_sx, r_s2_sy;
    logic                  r_s3_v;
    logic [AW-1:0]         r_s3_j;
    logic [DIST_BITS-1:0]  r_s3_d;

    logic    r_ov;
    t_result r_out;

    logic                  acc;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  set_full;
    logic [NB_W-1:0]       m_eff;
    logic [NB_W-1:0]       k_calc;
    logic                  start_scan;
    logic                  issue;
    logic                  busy;
    logic                  out_load;
    logic                  emit_last;
    logic [SQ_W-1:0]       ram_rdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0] abs_x, abs_y;
    t_list_ctl             list_ctl;
    logic [DIST_BITS-1:0]  list_dist;
    logic [INDEX_BITS-1:0] list_idx;

    assign o_ready = (r_state == ST_IDLE);
    assign acc     = i_valid && o_ready;

    // Index of the arriving point and the size of its neighbor list.
    always_comb begin
        cnt_eff  = i_point.new_set ? '0 : r_cnt;
        set_full = (cnt_eff >= CNT_W'(MAX_POINTS));
        if (r_ncount == '0) begin
            m_eff = NB_W'(1);
        end else if (32'(r_ncount) > 32'(MAX_NEIGHBORS)) begin
            m_eff = NB_W'(MAX_NEIGHBORS);
        end else begin
            m_eff = NB_W'(r_ncount);
        end
        k_calc     = (32'(cnt_eff) < 32'(m_eff)) ? NB_W'(cnt_eff) : m_eff;
        start_scan = !set_full && (k_calc != '0);
    end

    assign issue = (r_state == ST_SCAN) && (r_j < r_i);
    assign busy  = r_rv0 || r_s1_v || r_s2_v || r_s3_v;

    assign out_load  = (r_state == ST_EMIT) && (!r_ov || i_ready);
    assign emit_last = ((r_e + NB_W'(1)) == r_k);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && start_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register and set bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= NCOUNT_RESET;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ncount <= i_cfg_data;
            end
            if (acc) begin
                if (!set_full) begin
                    r_cnt <= cnt_eff + CNT_W'(1);
                end else begin
                    r_cnt <= cnt_eff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_i  <= cnt_eff[AW-1:0];
            r_k  <= k_calc;
            r_cx <= i_point.x_coord;
            r_cy <= i_point.y_coord;
        end
    end

    // Scan address and emit counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
            r_e <= '0;
        end else begin
            if (acc) begin
                r_j <= '0;
            end else if (issue) begin
                r_j <= r_j + AW'(1);
            end
            if (r_state == ST_SCAN) begin
                r_e <= '0;
            end else if (out_load) begin
                r_e <= r_e + NB_W'(1);
            end
        end
    end

    pknn_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_POINTS)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (acc && !set_full),
        .i_waddr (cnt_eff[AW-1:0]),
        .i_wdata ({i_point.x_coord, i_point.y_coord}),
        .i_raddr (r_j),
        .o_rdata (ram_rdata)
    );

    // Absolute coordinate differences against the point under work.
    always_comb begin
        rd_x   = ram_rdata[SQ_W-1:COORD_BITS];
        rd_y   = ram_rdata[COORD_BITS-1:0];
        diff_x = (COORD_BITS+1)'(r_cx) - (COORD_BITS+1)'(rd_x);
        diff_y = (COORD_BITS+1)'(r_cy) - (COORD_BITS+1)'(rd_y);
        abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
        abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv0  <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_rv0  <= issue;
            r_s1_v <= r_rv0;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rj0   <= r_j;
        r_s1_j  <= r_rj0;
        r_s1_dx <= abs_x;
        r_s1_dy <= abs_y;
        r_s2_j  <= r_s1_j;
        r_s2_sx <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
        r_s2_sy <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
        r_s3_j  <= r_s2_j;
        r_s3_d  <= DIST_BITS'(r_s2_sx) + DIST_BITS'(r_s2_sy);
    end

    always_comb begin
        list_ctl.clear     = acc;
        list_ctl.insert    = r_s3_v;
        list_ctl.cand_dist = r_s3_d;
        list_ctl.idx       = INDEX_BITS'(r_s3_j);
    end

    pknn_list #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (list_ctl),
        .i_rd_sel  (r_e[SEL_W-1:0]),
        .o_rd_dist (list_dist),
        .o_rd_idx  (list_idx)
    );

    // Output register: holds one result item until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.point_index    <= INDEX_BITS'(r_i);
            r_out.neighbor_index <= list_idx;
            r_out.distance_sq    <= list_dist;
            r_out.last_neighbor  <= emit_last;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule

// ===== rtl/pknn_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pknn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pknn_list.sv =====
// Sorted neighbor list kept in a row of compare-and-shift cells.
// Depends on pknn_pkg.
module pknn_list
    import pknn_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    localparam int SEL_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    localparam int NB_W  = $clog2(MAX_NEIGHBORS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_list_ctl             i_ctl,
    input  logic [SEL_W-1:0]      i_rd_sel,
    output logic [DIST_BITS-1:0]  o_rd_dist,
    output logic [INDEX_BITS-1:0] o_rd_idx
);

    logic [DIST_BITS-1:0]  r_dist [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0] r_idx  [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]  n_dist [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0] n_idx  [MAX_NEIGHBORS];
    logic [NB_W-1:0]       r_fill;
    logic [NB_W-1:0]       n_fill;
    logic [MAX_NEIGHBORS-1:0] gt;

    // An empty cell counts as farther than anything, so a candidate lands at the
    // first cell that is strictly farther; equal distances keep the earlier entry.
    always_comb begin
        for (int p = 0; p < MAX_NEIGHBORS; p++) begin
            gt[p] = (p >= int'(r_fill)) || (r_dist[p] > i_ctl.cand_dist);
        end
        n_dist[0] = gt[0] ? i_ctl.cand_dist : r_dist[0];
        n_idx[0]  = gt[0] ? i_ctl.idx  : r_idx[0];
        for (int p = 1; p < MAX_NEIGHBORS; p++) begin
            if (gt[p]) begin
                n_dist[p] = gt[p-1] ? r_dist[p-1] : i_ctl.cand_dist;
                n_idx[p]  = gt[p-1] ? r_idx[p-1]  : i_ctl.idx;
            end else begin
                n_dist[p] = r_dist[p];
                n_idx[p]  = r_idx[p];
            end
        end
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.insert && (r_fill != NB_W'(MAX_NEIGHBORS))) begin
            n_fill = r_fill + NB_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_dist <= n_dist;
            r_idx  <= n_idx;
        end
    end

    assign o_rd_dist = r_dist[i_rd_sel];
    assign o_rd_idx  = r_idx[i_rd_sel];

endmodule

// ===== test/pknn_result_checker.sv =====
// Checker for the prior-point k-nearest-neighbor search block.
// Depends on pknn_pkg; watches the configuration port and both channels of the block.
module pknn_result_checker
    import pknn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NCOUNT_BITS-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_point_in              i_point,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_result                i_result,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS_DEF];
    logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS_DEF];
    int unsigned                  set_count = 0;
    logic [NCOUNT_BITS-1:0]       ncount = NCOUNT_RESET;
    t_result                      expected_neighbors [$];
    int                           fail_total = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        fail_total++;
    endtask

    function automatic longint sq_dist(input logic signed [COORD_BITS-1:0] ax,
                                       input logic signed [COORD_BITS-1:0] ay,
                                       input logic signed [COORD_BITS-1:0] bx,
                                       input logic signed [COORD_BITS-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // Stores the point and queues the sorted list of its nearest earlier points.
    task automatic rank_nearest(input t_point_in pt);
        longint  best_d [MAX_NEIGHBORS_DEF];
        int      best_j [MAX_NEIGHBORS_DEF];
        int      idx;
        int      keep;
        int      filled;
        int      pos;
        longint  d;
        t_result r;
        if (pt.new_set)
            set_count = 0;
        // A full set ignores further points until the next new set.
        if (set_count >= MAX_POINTS_DEF)
            return;
        idx = set_count;
        x_mem[idx] = pt.x_coord;
        y_mem[idx] = pt.y_coord;
        set_count = idx + 1;
        if (ncount == 0)
            keep = 1;
        else if (ncount > MAX_NEIGHBORS_DEF)
            keep = MAX_NEIGHBORS_DEF;
        else
            keep = ncount;
        if (idx < keep)
            keep = idx;
        filled = 0;
        for (int j = 0; j < idx; j++) begin
            d = sq_dist(x_mem[idx], y_mem[idx], x_mem[j], y_mem[j]);
            if (filled < keep) begin
                pos = filled;
                filled++;
            end else if (d < best_d[keep-1]) begin
                pos = keep - 1;
            end else begin
                continue;
            end
            // Strict compare: an equal distance stays behind the earlier index.
            while (pos > 0 && best_d[pos-1] > d) begin
                best_d[pos] = best_d[pos-1];
                best_j[pos] = best_j[pos-1];
                pos--;
            end
            best_d[pos] = d;
            best_j[pos] = j;
        end
        for (int k = 0; k < keep; k++) begin
            r.point_index    = INDEX_BITS'(idx);
            r.neighbor_index = INDEX_BITS'(best_j[k]);
            r.distance_sq    = DIST_BITS'(best_d[k]);
            r.last_neighbor  = (k == keep - 1);
            expected_neighbors.push_back(r);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_neighbors.size() == 0) begin
            report_mismatch($sformatf("unexpected item: point %0d neighbor %0d dist %0d",
                                      got.point_index, got.neighbor_index, got.distance_sq));
            return;
        end
        want = expected_neighbors.pop_front();
        if (got.point_index !== want.point_index)
            report_mismatch($sformatf("point_index got %0d, expected %0d",
                                      got.point_index, want.point_index));
        if (got.neighbor_index !== want.neighbor_index)
            report_mismatch($sformatf("point %0d: neighbor_index got %0d, expected %0d",
                                      want.point_index, got.neighbor_index,
                                      want.neighbor_index));
        if (got.distance_sq !== want.distance_sq)
            report_mismatch($sformatf("point %0d: distance_sq got %0d, expected %0d",
                                      want.point_index, got.distance_sq, want.distance_sq));
        if (got.last_neighbor !== want.last_neighbor)
            report_mismatch($sformatf("point %0d: last_neighbor got %b, expected %b",
                                      want.point_index, got.last_neighbor,
                                      want.last_neighbor));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_count = 0;
            ncount = NCOUNT_RESET;
            expected_neighbors.delete();
        end else begin
            // Outputs first: a point taken at this edge cannot have results out yet.
            if (i_out_valid === 1'b1 && i_out_ready)
                check_result(i_result);
            if (i_in_valid && i_in_ready === 1'b1)
                rank_nearest(i_point);
            if (i_cfg_we)
                ncount = i_cfg_data;
        end
        o_pending    <= expected_neighbors.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== test/prior_point_knn_search_top_tb.sv =====
// Testbench top for the prior-point k-nearest-neighbor search block.
// Depends on pknn_pkg, the block's RTL and pknn_result_checker (test folder).
module prior_point_knn_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pknn_pkg::*;

    // Cycles allowed after the last expected item; covers a point that gives no items.
    localparam int DRAIN_CYCLES = 64;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 2000;

    // How coordinates of a random set are spread. Near values make many ties.
    typedef enum int {
        SPREAD_WIDE,
        SPREAD_NEAR,
        SPREAD_EDGE,
        SPREAD_MIX
    } t_spread;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [NCOUNT_BITS-1:0] i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    t_point_in              i_point;
    logic                   o_valid;
    logic                   i_ready;
    t_result                o_result;

    int      fail_count;
    int      pending;

    // Idle percentages of the sender and the receiver for the current phase.
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    // Each change of this counter asks the receiver for one long hold-off.
    int      hold_req       = 0;
    int      hold_seen      = 0;
    int      hold_left      = 0;
    // Random set generation: points left in the current set and its spread.
    int      set_left       = 0;
    t_spread spread         = SPREAD_WIDE;

    prior_point_knn_search_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_point    (i_point),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    pknn_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_point      (i_point),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: stalls at random at the phase's rate. A new hold-off request
    // drops ready for a long stretch so that the list and then the input back up.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Guard against a hung block or results that never come.
    initial begin
        #40_000_000;
        $display("prior_point_knn_search_top regression: fail");
        $finish;
    end

    function automatic t_point_in mk_point(input int x, input int y, input bit ns);
        t_point_in pt;
        pt.x_coord = COORD_BITS'(x);
        pt.y_coord = COORD_BITS'(y);
        pt.new_set = ns;
        return pt;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input t_spread how);
        case (how)
            SPREAD_WIDE: return COORD_BITS'($urandom());
            SPREAD_NEAR: return COORD_BITS'($urandom_range(8)) - COORD_BITS'(4);
            SPREAD_EDGE: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h8001;
                    2:       return 16'hFFFF;
                    3:       return 16'h0000;
                    default: return 16'h7FFF;
                endcase
            end
            default: return pick_coord(t_spread'($urandom_range(SPREAD_EDGE)));
        endcase
    endfunction

    // Sets are mostly short, sometimes long; a rare stray new_set breaks a set early.
    task automatic make_point(output t_point_in pt);
        if (set_left == 0) begin
            set_left = ($urandom_range(19) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
            spread = t_spread'($urandom_range(SPREAD_MIX));
            pt.new_set = 1'b1;
        end else begin
            pt.new_set = ($urandom_range(39) == 0);
        end
        set_left--;
        pt.x_coord = pick_coord(spread);
        pt.y_coord = pick_coord(spread);
    endtask

    // Offers one point at the falling edge after a random gap and holds it
    // until the block takes it at a rising edge.
    task automatic send_point(input t_point_in pt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // Stops offering, waits for every expected item, then lets the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the neighbor count; called only while the block is idle.
    task automatic write_ncount(input logic [NCOUNT_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random phase: a neighbor count, idle rates, and a number of points.
    // With press set, the receiver holds off for a long stretch early in the
    // phase while the sender keeps offering points.
    task automatic run_random(input int n_items, input logic [NCOUNT_BITS-1:0] value,
                              input int send_pct, input int stall_pct, input bit press);
        t_point_in pt;
        wait_drained();
        write_ncount(value);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        set_left       = 0;
        for (int n = 0; n < n_items; n++) begin
            if (press && n == 10)
                hold_req++;
            make_point(pt);
            send_point(pt);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_point    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset neighbor count, no idling.
        // A first point gives nothing; the corners give the largest distances.
        send_point(mk_point(0, 0, 1'b1));
        send_point(mk_point(-32768, -32768, 1'b0));
        send_point(mk_point(32767, 32767, 1'b0));
        send_point(mk_point(32767, -32768, 1'b0));
        send_point(mk_point(-32768, 32767, 1'b0));
        send_point(mk_point(0, 0, 1'b0));
        // A new set in the middle of a stream, then points at equal distances
        // so that ties must keep the earlier index first, and a duplicate point.
        send_point(mk_point(1, 0, 1'b1));
        send_point(mk_point(-1, 0, 1'b0));
        send_point(mk_point(0, 1, 1'b0));
        send_point(mk_point(0, -1, 1'b0));
        send_point(mk_point(0, 0, 1'b0));
        send_point(mk_point(0, 0, 1'b0));

        // With one neighbor kept, an equal distance must not replace the entry.
        wait_drained();
        write_ncount(NCOUNT_BITS'(1));
        send_point(mk_point(0, 0, 1'b1));
        send_point(mk_point(2, 0, 1'b0));
        send_point(mk_point(-2, 0, 1'b0));
        send_point(mk_point(0, 2, 1'b0));
        send_point(mk_point(1, 0, 1'b0));
        send_point(mk_point(-1, 0, 1'b0));

        // Random phases; counts of 0 and 31 are clamped by the block.
        run_random(70, NCOUNT_BITS'(MAX_NEIGHBORS_DEF), 0, 0, 1'b0);
        run_random(60, NCOUNT_BITS'(0), 80, 0, 1'b0);
        run_random(70, NCOUNT_BITS'(31), 0, 80, 1'b0);
        run_random(70, NCOUNT_BITS'($urandom_range(1, MAX_NEIGHBORS_DEF)), 14, 14, 1'b0);
        run_random(60, NCOUNT_BITS'(1), 0, 0, 1'b1);
        run_random(30, NCOUNT_BITS'($urandom_range(31)), 14, 14, 1'b0);

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("prior_point_knn_search_top regression: pass");
        end else begin
            $display("prior_point_knn_search_top regression: fail");
        end
        $finish;
    end

endmodule
